>>> rtl/haptic_pulse_train_sequencer_defines.svh
// Assertion macros shared by the pulse train sequencer RTL.
// Used by hpts_window and hpts_seq; depends on nothing else.
`ifndef HAPTIC_PULSE_TRAIN_SEQUENCER_DEFINES_SVH
`define HAPTIC_PULSE_TRAIN_SEQUENCER_DEFINES_SVH

// The property must hold in the same cycle as the condition.
`define HPTS_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// The property must hold in the cycle after the condition.
`define HPTS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> rtl/hpts_pkg.sv
// Package for the haptic pulse train sequencer: widths, register indexes,
// reset values and the request, result, stage and configuration structs.
// Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hpts_pkg;

   localparam int TICK_MS_PER_SECOND = 1000;

   localparam int DUR_W       = 16;
   localparam int COUNT_W     = 8;
   localparam int HOLD_W      = 8;
   localparam int AMP_W       = 8;
   localparam int PWR_W       = 8;
   localparam int TIME_W      = 32;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;

   localparam int TICK_W    = $clog2(TICK_MS_PER_SECOND + 1);
   localparam int HOLD_MS_W = HOLD_W + TICK_W;
   localparam int PROD_W    = DUR_W + COUNT_W;
   localparam int WIN_MAX   = 2 * ((2 ** COUNT_W) - 1) * ((2 ** DUR_W) - 1)
                              + ((2 ** HOLD_W) - 1) * TICK_MS_PER_SECOND
                              + ((2 ** DUR_W) - 1);
   localparam int WIN_W     = $clog2(WIN_MAX + 1);

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_DURATION,
      CSR_MAX_DURATION,
      CSR_MAX_GAP,
      CSR_MAX_REPEAT,
      CSR_MAX_HOLD,
      CSR_DRIVE_AMPLITUDE,
      CSR_GUARD,
      CSR_POWERUP
   } csr_index_type;

   localparam logic [DUR_W-1:0]   RST_MIN_DURATION    = 16'd10;
   localparam logic [DUR_W-1:0]   RST_MAX_DURATION    = 16'd2000;
   localparam logic [DUR_W-1:0]   RST_MAX_GAP         = 16'd2000;
   localparam logic [COUNT_W-1:0] RST_MAX_REPEAT      = 8'd10;
   localparam logic [HOLD_W-1:0]  RST_MAX_HOLD        = 8'd30;
   localparam logic [AMP_W-1:0]   RST_DRIVE_AMPLITUDE = 8'h7F;
   localparam logic [DUR_W-1:0]   RST_GUARD           = 16'd500;
   localparam logic [PWR_W-1:0]   RST_POWERUP         = 8'h05;

   typedef struct packed {
      logic [DUR_W-1:0]   min_duration_ms;
      logic [DUR_W-1:0]   max_duration_ms;
      logic [DUR_W-1:0]   max_gap_ms;
      logic [COUNT_W-1:0] max_repeat_count;
      logic [HOLD_W-1:0]  max_hold_seconds;
      logic [AMP_W-1:0]   drive_amplitude;
      logic [DUR_W-1:0]   guard_ms;
      logic [PWR_W-1:0]   powerup_ms;
   } cfg_type;

   typedef struct packed {
      logic               command;
      logic [DUR_W-1:0]   pulse_ms;
      logic [COUNT_W-1:0] pulse_count;
      logic [DUR_W-1:0]   gap_ms;
      logic [HOLD_W-1:0]  hold_seconds;
   } req_type;

   typedef struct packed {
      logic             accepted;
      logic [AMP_W-1:0] drive_level;
      logic             driver_powered;
      logic             driver_realtime;
      logic             running;
      logic             active;
   } rsp_type;

   typedef struct packed {
      logic                 command;
      logic                 ok;
      logic [DUR_W-1:0]     pulse_ms;
      logic [COUNT_W-1:0]   pulse_count;
      logic [DUR_W-1:0]     gap_ms;
      logic [HOLD_MS_W-1:0] hold_ms;
      logic [WIN_W-1:0]     win_base;
   } stage_type;

endpackage

`default_nettype wire

>>> rtl/hpts_window.sv
// Front pipeline of the sequencer: limit checks and window products in the
// first stage, window sum in the second. Depends on hpts_pkg and the defines.
`timescale 1ns / 1ps
`default_nettype none
`include "haptic_pulse_train_sequencer_defines.svh"

module hpts_window (
   input  logic               clock,
   input  logic               reset,
   input  hpts_pkg::cfg_type  cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  hpts_pkg::req_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output hpts_pkg::stage_type out_data
);

   typedef struct packed {
      logic                           command;
      logic                           ok;
      logic [hpts_pkg::DUR_W-1:0]     pulse_ms;
      logic [hpts_pkg::COUNT_W-1:0]   pulse_count;
      logic [hpts_pkg::DUR_W-1:0]     gap_ms;
      logic [hpts_pkg::HOLD_MS_W-1:0] hold_ms;
      logic [hpts_pkg::PROD_W-1:0]    pulse_prod;
      logic [hpts_pkg::PROD_W-1:0]    gap_prod;
   } s1_type;

   logic                         v1_ff;
   logic                         v2_ff;
   s1_type                       s1_ff;
   s1_type                       s1_in;
   hpts_pkg::stage_type          s2_ff;
   hpts_pkg::stage_type          s2_in;
   logic                         ready2;
   logic [hpts_pkg::COUNT_W-1:0] gap_count;

   assign ready2   = !v2_ff || out_ready;
   assign in_ready = !v1_ff || ready2;

   always_comb begin
      gap_count = (in_data.pulse_count != '0) ?
                  in_data.pulse_count - hpts_pkg::COUNT_W'(1) : '0;

      s1_in.command     = in_data.command;
      s1_in.ok          = (in_data.pulse_ms >= cfg.min_duration_ms) &&
                          (in_data.pulse_ms <= cfg.max_duration_ms) &&
                          (in_data.pulse_count != '0) &&
                          (in_data.pulse_count <= cfg.max_repeat_count) &&
                          (in_data.gap_ms <= cfg.max_gap_ms) &&
                          (in_data.hold_seconds <= cfg.max_hold_seconds);
      s1_in.pulse_ms    = in_data.pulse_ms;
      s1_in.pulse_count = in_data.pulse_count;
      s1_in.gap_ms      = in_data.gap_ms;
      s1_in.hold_ms     = hpts_pkg::HOLD_MS_W'(in_data.hold_seconds) *
                          hpts_pkg::HOLD_MS_W'(hpts_pkg::TICK_MS_PER_SECOND);
      s1_in.pulse_prod  = hpts_pkg::PROD_W'(in_data.pulse_count) *
                          hpts_pkg::PROD_W'(in_data.pulse_ms);
      s1_in.gap_prod    = hpts_pkg::PROD_W'(gap_count) *
                          hpts_pkg::PROD_W'(in_data.gap_ms);
   end

   always_comb begin
      s2_in.command     = s1_ff.command;
      s2_in.ok          = s1_ff.ok;
      s2_in.pulse_ms    = s1_ff.pulse_ms;
      s2_in.pulse_count = s1_ff.pulse_count;
      s2_in.gap_ms      = s1_ff.gap_ms;
      s2_in.hold_ms     = s1_ff.hold_ms;
      s2_in.win_base    = hpts_pkg::WIN_W'(s1_ff.pulse_prod) +
                          hpts_pkg::WIN_W'(s1_ff.gap_prod) +
                          hpts_pkg::WIN_W'(s1_ff.hold_ms);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            v1_ff <= in_valid;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
      end
      if (in_ready && in_valid) begin
         s1_ff <= s1_in;
      end
      if (ready2 && v1_ff) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = s2_ff;

   `HPTS_ASSERT_NEXT(a_s1_holds, clock, reset, v1_ff && !ready2, v1_ff && $stable(s1_ff), "first stage lost a stalled request")
   `HPTS_ASSERT_NEXT(a_s2_holds, clock, reset, v2_ff && !out_ready, v2_ff && $stable(s2_ff), "second stage lost a stalled request")

endmodule

`default_nettype wire

>>> rtl/hpts_seq.sv
// Sequencer state stage: pending slot, phase counters, stay-awake deadline
// and the result register. Depends on hpts_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "haptic_pulse_train_sequencer_defines.svh"

module hpts_seq (
   input  logic                clock,
   input  logic                reset,
   input  hpts_pkg::cfg_type   cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  hpts_pkg::stage_type in_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output hpts_pkg::rsp_type   rsp_data
);

   typedef enum logic [1:0] {PH_IDLE, PH_POWERUP, PH_PULSE, PH_GAP} phase_type;

   typedef struct packed {
      phase_type                    phase;
      logic [hpts_pkg::DUR_W-1:0]   left;
      logic [hpts_pkg::COUNT_W-1:0] pulses;
      logic                         finished;
   } run_type;

   function automatic run_type begin_pulse(input logic [hpts_pkg::COUNT_W-1:0] count,
                                           input logic [hpts_pkg::DUR_W-1:0]   pulse,
                                           input logic [hpts_pkg::DUR_W-1:0]   gap);
      run_type                      r;
      logic [hpts_pkg::COUNT_W-1:0] rest;
      rest       = count - hpts_pkg::COUNT_W'(1);
      r.pulses   = rest;
      r.finished = 1'b0;
      if (pulse != '0) begin
         r.phase = PH_PULSE;
         r.left  = pulse;
      end else if ((gap != '0) && (rest != '0)) begin
         r.phase = PH_GAP;
         r.left  = gap;
      end else begin
         r.phase    = PH_IDLE;
         r.left     = '0;
         r.finished = 1'b1;
      end
      return r;
   endfunction

   // Walks through every phase whose time has run out; a zero pulse with
   // a zero gap collapses the remaining pulses at once.
   function automatic run_type advance(input run_type                    cur,
                                       input logic [hpts_pkg::DUR_W-1:0] pulse,
                                       input logic [hpts_pkg::DUR_W-1:0] gap);
      run_type r;
      r          = cur;
      r.finished = 1'b0;
      if ((cur.phase != PH_IDLE) && (cur.left == '0)) begin
         unique case (cur.phase)
            PH_POWERUP: begin
               if (cur.pulses != '0) begin
                  r = begin_pulse(cur.pulses, pulse, gap);
               end else begin
                  r.phase    = PH_IDLE;
                  r.finished = 1'b1;
               end
            end
            PH_PULSE: begin
               if (cur.pulses == '0) begin
                  r.phase    = PH_IDLE;
                  r.finished = 1'b1;
               end else if (gap != '0) begin
                  r.phase = PH_GAP;
                  r.left  = gap;
               end else begin
                  r = begin_pulse(cur.pulses, pulse, gap);
               end
            end
            PH_GAP: begin
               r = begin_pulse(cur.pulses, pulse, gap);
            end
            PH_IDLE: begin
               r = cur;
            end
         endcase
      end
      return r;
   endfunction

   function automatic logic later_than(input logic [hpts_pkg::WIN_W-1:0]  x,
                                       input logic [hpts_pkg::TIME_W-1:0] rel);
      logic [hpts_pkg::TIME_W-1:0] diff;
      diff = hpts_pkg::TIME_W'(x) - rel;
      return (diff != '0) && !diff[hpts_pkg::TIME_W-1];
   endfunction

   // The deadline is kept relative to the millisecond clock.
   logic [hpts_pkg::TIME_W-1:0]    rel_ff;
   logic [hpts_pkg::TIME_W-1:0]    rel_in;
   logic                           busy_ff;
   logic                           busy_in;
   logic                           slot_valid_ff;
   logic                           slot_valid_in;
   phase_type                      phase_ff;
   logic [hpts_pkg::DUR_W-1:0]     left_ff;
   logic [hpts_pkg::COUNT_W-1:0]   pulses_ff;
   run_type                        run_in;
   logic                           rsp_valid_ff;
   hpts_pkg::rsp_type              rsp_ff;
   hpts_pkg::rsp_type              rsp_in;

   logic [hpts_pkg::DUR_W-1:0]     slot_pulse_ff;
   logic [hpts_pkg::COUNT_W-1:0]   slot_count_ff;
   logic [hpts_pkg::DUR_W-1:0]     slot_gap_ff;
   logic [hpts_pkg::HOLD_MS_W-1:0] slot_hold_ff;
   logic [hpts_pkg::WIN_W-1:0]     slot_win_ff;
   logic [hpts_pkg::DUR_W-1:0]     cur_pulse_ff;
   logic [hpts_pkg::DUR_W-1:0]     cur_gap_ff;
   logic [hpts_pkg::HOLD_MS_W-1:0] cur_hold_ff;

   logic                           fire;
   logic                           tick;
   logic                           acc;
   logic                           pickup;
   logic                           load_slot;
   logic                           finish1;
   logic                           finish2;
   run_type                        run_now;
   run_type                        run_dec;
   run_type                        run1;
   run_type                        run2;
   logic [hpts_pkg::DUR_W-1:0]     src_pulse;
   logic [hpts_pkg::COUNT_W-1:0]   src_count;
   logic [hpts_pkg::DUR_W-1:0]     src_gap;
   logic [hpts_pkg::HOLD_MS_W-1:0] src_hold;
   logic [hpts_pkg::WIN_W-1:0]     src_win;
   logic [hpts_pkg::WIN_W-1:0]     x_win;
   logic [hpts_pkg::WIN_W-1:0]     x1;
   logic [hpts_pkg::WIN_W-1:0]     x3;
   logic                           e1;
   logic                           g1;
   logic                           g2;
   logic                           g3;
   logic [hpts_pkg::TIME_W-1:0]    rel_base;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign fire     = in_valid && in_ready;

   always_comb begin
      tick      = (in_data.command == hpts_pkg::CMD_TICK);
      acc       = !tick && in_data.ok && !slot_valid_ff;
      load_slot = acc && (phase_ff != PH_IDLE);

      run_now = '{phase: phase_ff, left: left_ff, pulses: pulses_ff, finished: 1'b0};
      run_dec = run_now;
      if ((phase_ff != PH_IDLE) && (left_ff != '0)) begin
         run_dec.left = left_ff - hpts_pkg::DUR_W'(1);
      end
      run1 = tick ? advance(run_dec, cur_pulse_ff, cur_gap_ff) : run_now;

      src_pulse = tick ? slot_pulse_ff : in_data.pulse_ms;
      src_count = tick ? slot_count_ff : in_data.pulse_count;
      src_gap   = tick ? slot_gap_ff   : in_data.gap_ms;
      src_hold  = tick ? slot_hold_ff  : in_data.hold_ms;
      src_win   = tick ? slot_win_ff   : in_data.win_base;

      pickup = tick ? ((run1.phase == PH_IDLE) && slot_valid_ff)
                    : (acc && (phase_ff == PH_IDLE));
      run2   = advance('{phase: PH_POWERUP, left: hpts_pkg::DUR_W'(cfg.powerup_ms),
                         pulses: src_count, finished: 1'b0}, src_pulse, src_gap);
      run_in = pickup ? run2 : run1;

      finish1 = tick && run1.finished;
      finish2 = pickup && run2.finished;

      busy_in = busy_ff;
      if (finish1) begin
         busy_in = 1'b0;
      end
      if (acc || pickup) begin
         busy_in = 1'b1;
      end
      if (finish2) begin
         busy_in = 1'b0;
      end

      slot_valid_in = slot_valid_ff;
      if (load_slot) begin
         slot_valid_in = 1'b1;
      end else if (tick && pickup) begin
         slot_valid_in = 1'b0;
      end

      // Up to three deadline raises per request, applied in order.
      x_win    = src_win + hpts_pkg::WIN_W'(cfg.guard_ms);
      x1       = tick ? hpts_pkg::WIN_W'(cur_hold_ff) : x_win;
      e1       = tick ? finish1 : acc;
      x3       = hpts_pkg::WIN_W'(src_hold);
      rel_base = tick ? rel_ff - hpts_pkg::TIME_W'(1) : rel_ff;

      g1 = e1 && later_than(x1, rel_base);
      g2 = pickup && (g1 ? (x_win > x1) : later_than(x_win, rel_base));
      g3 = finish2 && (g2 ? (x3 > x_win) :
                       g1 ? (x3 > x1) : later_than(x3, rel_base));

      priority if (g3) begin
         rel_in = hpts_pkg::TIME_W'(x3);
      end else if (g2) begin
         rel_in = hpts_pkg::TIME_W'(x_win);
      end else if (g1) begin
         rel_in = hpts_pkg::TIME_W'(x1);
      end else begin
         rel_in = rel_base;
      end

      rsp_in.accepted        = acc;
      rsp_in.drive_level     = (run_in.phase == PH_PULSE) ? cfg.drive_amplitude : '0;
      rsp_in.driver_powered  = (run_in.phase != PH_IDLE);
      rsp_in.driver_realtime = (run_in.phase == PH_PULSE) || (run_in.phase == PH_GAP);
      rsp_in.running         = busy_in;
      rsp_in.active          = busy_in ||
                               ((rel_in != '0) && !rel_in[hpts_pkg::TIME_W-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         rel_ff        <= '0;
         busy_ff       <= 1'b0;
         slot_valid_ff <= 1'b0;
         phase_ff      <= PH_IDLE;
         left_ff       <= '0;
         pulses_ff     <= '0;
      end else begin
         if (in_ready) begin
            rsp_valid_ff <= in_valid;
         end
         if (fire) begin
            rel_ff        <= rel_in;
            busy_ff       <= busy_in;
            slot_valid_ff <= slot_valid_in;
            phase_ff      <= run_in.phase;
            left_ff       <= run_in.left;
            pulses_ff     <= run_in.pulses;
            rsp_ff        <= rsp_in;
            if (load_slot) begin
               slot_pulse_ff <= in_data.pulse_ms;
               slot_count_ff <= in_data.pulse_count;
               slot_gap_ff   <= in_data.gap_ms;
               slot_hold_ff  <= in_data.hold_ms;
               slot_win_ff   <= in_data.win_base;
            end
            if (pickup) begin
               cur_pulse_ff <= src_pulse;
               cur_gap_ff   <= src_gap;
               cur_hold_ff  <= src_hold;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `HPTS_ASSERT_NOW(a_slot_needs_run, clock, reset, slot_valid_ff, busy_ff && (phase_ff != PH_IDLE), "pending request held while nothing runs")
   `HPTS_ASSERT_NOW(a_phase_busy, clock, reset, phase_ff != PH_IDLE, busy_ff, "driver phase active without running flag")
   `HPTS_ASSERT_NEXT(a_reject_keeps, clock, reset, fire && !tick && !acc, $stable(rel_ff) && $stable(busy_ff) && $stable(phase_ff) && $stable(slot_valid_ff), "rejected start changed the state")

endmodule

`default_nettype wire

>>> rtl/haptic_pulse_train_sequencer.sv
// Top level of the haptic pulse train sequencer: configuration registers
// and the two pipeline parts. Depends on hpts_pkg, hpts_window, hpts_seq.
//
// Usage: each request on req_ is either a start (command 0, with pulse
// time, pulse count, gap and hold seconds) or a 1 ms tick (command 1).
// Every request yields exactly one result on rsp_, in request order, with
// the accepted flag, drive level, driver power and mode, running and active.
// A request passes a check stage and a window stage, and the state stage
// registers its result in the output register. One request per cycle is
// taken in steady state while rsp_ready stays high; the pipeline stages and
// the single state stage that updates the slot, phase counters and deadline
// set that rate. When the receiver holds rsp_ready low the result waits in
// the output register while the front stages keep filling; req_ready drops
// only when every stage is full. The csr_ port writes one configuration
// register per cycle. Synchronous reset restores the register defaults,
// empties the pipeline, clears the pending slot and leaves the driver idle
// with time at zero.
`timescale 1ns / 1ps
`default_nettype none

module haptic_pulse_train_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  hpts_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output hpts_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [hpts_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hpts_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   hpts_pkg::cfg_type   cfg_ff;
   hpts_pkg::cfg_type   cfg_in;
   logic                mid_valid;
   logic                mid_ready;
   hpts_pkg::stage_type mid_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (hpts_pkg::csr_index_type'(csr_index))
            hpts_pkg::CSR_MIN_DURATION:
               cfg_in.min_duration_ms = csr_wdata[hpts_pkg::DUR_W-1:0];
            hpts_pkg::CSR_MAX_DURATION:
               cfg_in.max_duration_ms = csr_wdata[hpts_pkg::DUR_W-1:0];
            hpts_pkg::CSR_MAX_GAP:
               cfg_in.max_gap_ms = csr_wdata[hpts_pkg::DUR_W-1:0];
            hpts_pkg::CSR_MAX_REPEAT:
               cfg_in.max_repeat_count = csr_wdata[hpts_pkg::COUNT_W-1:0];
            hpts_pkg::CSR_MAX_HOLD:
               cfg_in.max_hold_seconds = csr_wdata[hpts_pkg::HOLD_W-1:0];
            hpts_pkg::CSR_DRIVE_AMPLITUDE:
               cfg_in.drive_amplitude = csr_wdata[hpts_pkg::AMP_W-1:0];
            hpts_pkg::CSR_GUARD:
               cfg_in.guard_ms = csr_wdata[hpts_pkg::DUR_W-1:0];
            hpts_pkg::CSR_POWERUP:
               cfg_in.powerup_ms = csr_wdata[hpts_pkg::PWR_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_duration_ms  <= hpts_pkg::RST_MIN_DURATION;
         cfg_ff.max_duration_ms  <= hpts_pkg::RST_MAX_DURATION;
         cfg_ff.max_gap_ms       <= hpts_pkg::RST_MAX_GAP;
         cfg_ff.max_repeat_count <= hpts_pkg::RST_MAX_REPEAT;
         cfg_ff.max_hold_seconds <= hpts_pkg::RST_MAX_HOLD;
         cfg_ff.drive_amplitude  <= hpts_pkg::RST_DRIVE_AMPLITUDE;
         cfg_ff.guard_ms         <= hpts_pkg::RST_GUARD;
         cfg_ff.powerup_ms       <= hpts_pkg::RST_POWERUP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hpts_window u_window (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_payload),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_data)
   );

   hpts_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_payload)
   );

endmodule

`default_nettype wire
